// ----- hw/rtl/drss_pkg.sv -----
`default_nettype none
package drss_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_A_MIN_GREEN    = 3'd0;
  localparam logic [2:0] CFG_A_MAX_GREEN    = 3'd1;
  localparam logic [2:0] CFG_EXTENSION_STEP = 3'd2;
  localparam logic [2:0] CFG_ENTRY_CLEAR    = 3'd3;
  localparam logic [2:0] CFG_EXIT_CLEAR     = 3'd4;
  localparam logic [2:0] CFG_B_MIN_GREEN    = 3'd5;
  localparam logic [2:0] CFG_B_MAX_GREEN    = 3'd6;
  localparam logic [2:0] CFG_B_CLEAR        = 3'd7;

  localparam logic [7:0] SAT_MAX    = 8'd255;
  localparam logic [7:0] LAMP_RESET = 8'hA5;
  localparam logic [1:0] LAMP_RED   = 2'b01;
  localparam logic [1:0] LAMP_GREEN = 2'b10;

  typedef enum logic [2:0] {
    A_MIN_GREEN   = 3'd0,
    A_EXTEND      = 3'd1,
    A_ENTRY_CLEAR = 3'd2,
    A_G1_MIN      = 3'd3,
    A_G1_EXTEND   = 3'd4,
    A_LOOP_WAIT   = 3'd5,
    A_EXIT_CLEAR  = 3'd6
  } step_a_e;

  typedef enum logic [2:0] {
    B_MIN_GREEN  = 3'd0,
    B_EXTEND     = 3'd1,
    B_CLEAR      = 3'd2,
    B_REV_MIN    = 3'd3,
    B_REV_EXTEND = 3'd4,
    B_CLEAR_BACK = 3'd5
  } step_b_e;

  typedef struct packed {
    logic [7:0] a_min_green;
    logic [7:0] a_max_green;
    logic [7:0] extension_step;
    logic [7:0] entry_clear;
    logic [7:0] exit_clear;
    logic [7:0] b_min_green;
    logic [7:0] b_max_green;
    logic [7:0] b_clear;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    a_min_green:    8'd10,
    a_max_green:    8'd20,
    extension_step: 8'd6,
    entry_clear:    8'd20,
    exit_clear:     8'd20,
    b_min_green:    8'd10,
    b_max_green:    8'd15,
    b_clear:        8'd20
  };

  typedef struct packed {
    logic second_tick;
    logic loop_one_busy;
    logic loop_two_busy;
    logic sugar_call_pulse;
    logic forklift_call_pulse;
  } item_in_t;

  typedef struct packed {
    logic [7:0] timer_a;
    logic [7:0] timer_b;
    step_a_e    step_a;
    step_b_e    step_b;
    logic [7:0] accum_a;
    logic [7:0] accum_b;
    logic       sugar_request;
    logic       forklift_request;
    logic       sugar_call;
    logic       clearance_done;
    logic [7:0] lamp;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    timer_a:          8'd0,
    timer_b:          8'd0,
    step_a:           A_MIN_GREEN,
    step_b:           B_MIN_GREEN,
    accum_a:          8'd0,
    accum_b:          8'd0,
    sugar_request:    1'b0,
    forklift_request: 1'b0,
    sugar_call:       1'b0,
    clearance_done:   1'b0,
    lamp:             LAMP_RESET
  };

endpackage
`default_nettype wire

// ----- hw/rtl/drss_eval.sv -----
`default_nettype none
module drss_eval
  import drss_pkg::*;
(
  input  var cfg_t       cfg_i,
  input  var item_in_t   item_i,
  input  var seq_state_t cur_i,
  output seq_state_t     nxt_o
);

  function automatic logic [7:0] floor_sub(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? SAT_MAX : s[7:0];
  endfunction

  logic [7:0] base_a;
  logic [7:0] base_b;
  logic [7:0] acc_a;
  logic [7:0] acc_b;
  seq_state_t s;

  assign base_a = floor_sub(cfg_i.a_min_green, cfg_i.extension_step);
  assign base_b = floor_sub(cfg_i.b_min_green, cfg_i.extension_step);

  always_comb begin
    s = cur_i;
    acc_a = sat_add(cur_i.accum_a, cfg_i.extension_step);
    acc_b = sat_add(cur_i.accum_b, cfg_i.extension_step);

    // tick and request latches come first
    if (item_i.second_tick) begin
      if (s.timer_a != SAT_MAX) s.timer_a = s.timer_a + 8'd1;
      if (s.timer_b != SAT_MAX) s.timer_b = s.timer_b + 8'd1;
    end
    if (item_i.sugar_call_pulse) s.sugar_request = 1'b1;
    if (item_i.forklift_call_pulse) s.forklift_request = 1'b1;

    // ramp A drives groups one and four
    unique case (s.step_a)
      A_MIN_GREEN: begin
        if (s.timer_a >= base_a) begin
          s.step_a = A_EXTEND; s.accum_a = base_a; s.timer_a = 8'd0;
        end
      end
      A_EXTEND: begin
        if (s.timer_a >= cfg_i.extension_step) begin
          s.accum_a = acc_a;
          s.timer_a = 8'd0;
          if (acc_a > cfg_i.a_max_green && s.sugar_request) begin
            s.step_a = A_ENTRY_CLEAR;
            s.lamp[1:0] = LAMP_RED; s.lamp[7:6] = LAMP_RED;
            s.sugar_call = 1'b1;
          end
        end
      end
      A_ENTRY_CLEAR: begin
        if (s.timer_a >= cfg_i.entry_clear && cur_i.clearance_done) begin
          s.step_a = A_G1_MIN; s.timer_a = 8'd0;
          s.lamp[1:0] = LAMP_GREEN; s.lamp[7:6] = LAMP_RED;
        end
      end
      A_G1_MIN: begin
        if (s.timer_a >= base_a) begin
          s.sugar_request = 1'b0; s.step_a = A_G1_EXTEND;
          s.accum_a = base_a; s.timer_a = 8'd0;
        end
      end
      A_G1_EXTEND: begin
        if (s.timer_a >= cfg_i.extension_step) begin
          s.accum_a = acc_a;
          if (item_i.loop_one_busy && item_i.loop_two_busy) begin
            s.step_a = A_LOOP_WAIT;
            s.lamp[1:0] = LAMP_RED; s.lamp[7:6] = LAMP_RED;
            s.sugar_call = 1'b0;
          end else begin
            s.timer_a = 8'd0;
          end
        end
      end
      A_LOOP_WAIT: begin
        // timer keeps running from the extension phase
        if (!item_i.loop_one_busy && !item_i.loop_two_busy) begin
          s.step_a = A_EXIT_CLEAR; s.timer_a = 8'd0;
        end
      end
      A_EXIT_CLEAR: begin
        if (s.timer_a >= cfg_i.exit_clear) begin
          s.step_a = A_MIN_GREEN; s.timer_a = 8'd0;
          s.lamp[1:0] = LAMP_RED; s.lamp[7:6] = LAMP_GREEN;
        end
      end
      default: begin
      end
    endcase

    // ramp B drives groups two and three, sees ramp A's updated call
    unique case (s.step_b)
      B_MIN_GREEN: begin
        if (s.timer_b >= base_b) begin
          s.step_b = B_EXTEND; s.accum_b = base_b; s.timer_b = 8'd0;
        end
      end
      B_EXTEND: begin
        if (s.timer_b >= cfg_i.extension_step) begin
          s.accum_b = acc_b;
          s.timer_b = 8'd0;
          if (acc_b > cfg_i.b_max_green && (s.forklift_request || s.sugar_call)) begin
            s.step_b = B_CLEAR;
            s.lamp[3:2] = LAMP_RED; s.lamp[5:4] = LAMP_RED;
          end
        end
      end
      B_CLEAR: begin
        if (s.timer_b >= cfg_i.b_clear) begin
          s.clearance_done = 1'b1; s.step_b = B_REV_MIN; s.timer_b = 8'd0;
          s.lamp[3:2] = LAMP_GREEN; s.lamp[5:4] = LAMP_RED;
        end
      end
      B_REV_MIN: begin
        if (s.timer_b >= base_b) begin
          s.forklift_request = 1'b0; s.step_b = B_REV_EXTEND;
          s.accum_b = base_b; s.timer_b = 8'd0;
        end
      end
      B_REV_EXTEND: begin
        if (s.timer_b >= cfg_i.extension_step) begin
          s.accum_b = acc_b;
          s.timer_b = 8'd0;
          if ((acc_b > cfg_i.b_max_green || !s.forklift_request) && !s.sugar_call) begin
            s.step_b = B_CLEAR_BACK;
            s.lamp[3:2] = LAMP_RED; s.lamp[5:4] = LAMP_RED;
          end else begin
            s.forklift_request = 1'b0;
          end
        end
      end
      B_CLEAR_BACK: begin
        if (s.timer_b >= cfg_i.b_clear) begin
          s.step_b = B_MIN_GREEN; s.timer_b = 8'd0;
          s.lamp[3:2] = LAMP_RED; s.lamp[5:4] = LAMP_GREEN;
        end
      end
      default: begin
      end
    endcase

    nxt_o = s;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dual_ramp_signal_sequencer.sv -----
`default_nettype none
// Dual ramp signal sequencer: two interlocked lamp sequencers, ramp A (7 steps)
// and ramp B (6 steps), driving four signal groups.
// Input stream (s_axis): one item per evaluation pass, carrying the second tick,
// both loop levels and the sugar and forklift call pulses.
// Output stream (m_axis): one item per input item, carrying the lamp bits, both
// step numbers and the sugar call flag, all taken after the pass.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i on the
// clock edge; write only while no item is in flight.
// An accepted item is held in the input register; its result is registered in
// the result register. Throughput is one item per cycle while m_axis_tready is
// high; the pass is a single stage of compares and saturating adds between
// them, and the sequencer state updates together with the result register.
// The result register holds its item while m_axis_tready is low; one more item
// may wait in the input register, then s_axis_tready drops.
// Reset: both ramps go to step 0, timers, accumulators and latches clear, the
// lamps show groups one and two red and three and four green, and the
// configuration registers return to their default times.
module dual_ramp_signal_sequencer
  import drss_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  // [0] second_tick, [1] loop_one_busy, [2] loop_two_busy,
  // [3] sugar_call_pulse, [4] forklift_call_pulse, [7:5] zero
  input  wire  [7:0] s_axis_tdata,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  // [7:0] lamp_bits, [10:8] ramp_a_step, [13:11] ramp_b_step,
  // [14] sugar_call_active, [15] zero
  output logic [15:0] m_axis_tdata,
  input  wire        cfg_we_i,
  input  wire  [2:0] cfg_idx_i,
  input  wire  [7:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  seq_state_t st_q;
  seq_state_t st_d;
  item_in_t   in_q;
  logic       in_valid_q;
  logic       out_valid_q;
  logic [15:0] out_data_q;
  logic       advance;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  drss_eval u_eval (
    .cfg_i  (cfg_q),
    .item_i (in_q),
    .cur_i  (st_q),
    .nxt_o  (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_MIN_GREEN:    cfg_q.a_min_green    <= cfg_wdata_i;
        CFG_A_MAX_GREEN:    cfg_q.a_max_green    <= cfg_wdata_i;
        CFG_EXTENSION_STEP: cfg_q.extension_step <= cfg_wdata_i;
        CFG_ENTRY_CLEAR:    cfg_q.entry_clear    <= cfg_wdata_i;
        CFG_EXIT_CLEAR:     cfg_q.exit_clear     <= cfg_wdata_i;
        CFG_B_MIN_GREEN:    cfg_q.b_min_green    <= cfg_wdata_i;
        CFG_B_MAX_GREEN:    cfg_q.b_max_green    <= cfg_wdata_i;
        CFG_B_CLEAR:        cfg_q.b_clear        <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= STATE_RESET;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) st_q <= st_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.second_tick         <= s_axis_tdata[0];
      in_q.loop_one_busy       <= s_axis_tdata[1];
      in_q.loop_two_busy       <= s_axis_tdata[2];
      in_q.sugar_call_pulse    <= s_axis_tdata[3];
      in_q.forklift_call_pulse <= s_axis_tdata[4];
    end
    if (advance && in_valid_q) begin
      out_data_q <= {1'b0, st_d.sugar_call, 3'(st_d.step_b), 3'(st_d.step_a), st_d.lamp};
    end
  end

endmodule
`default_nettype wire
